// File: hdl/lstm_cell_with_dense_head_defines.svh
// Assertion macros shared by the checker.
`ifndef LSTM_CELL_WITH_DENSE_HEAD_DEFINES_SVH
`define LSTM_CELL_WITH_DENSE_HEAD_DEFINES_SVH
// implication checked on every clock edge outside reset
`define LCDH_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// next-cycle implication
`define LCDH_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// File: hdl/lcdh_pkg.sv
// ----------------------------------------------------------------------------
// lcdh_pkg
// Types, codes and activation table for the LSTM cell with dense head.
// ----------------------------------------------------------------------------
package lcdh_pkg;
    localparam int KindW  = 3;
    localparam int SlotW  = 12;
    localparam int DataW  = 16;

    typedef enum logic [KindW-1:0] {
        K_LOAD_IN  = 3'd0,
        K_LOAD_REC = 3'd1,
        K_LOAD_BIA = 3'd2,
        K_LOAD_DNS = 3'd3,
        K_STEP     = 3'd4,
        K_CLEAR    = 3'd5
    } t_kind;

    // datapath accumulator operand selects
    typedef enum logic [2:0] {
        OP_NONE,
        OP_GATE_X,     // acc = w_in*x + bias<<12
        OP_GATE_REC,   // acc += w_rec*h[j]
        OP_GATE_ACT,   // finish gate g of unit u
        OP_CELL,       // c/h update of unit u
        OP_HTANH,      // first: store c, tanh(c); else acc = o*tanh(c)
        OP_DENSE,      // acc += h[u]*w_d
        OP_DONE        // saturate prediction
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] gate;
        logic [4:0] unit;
        logic [4:0] col;
        logic       first;
        logic       clear;
    } t_cmd;

    function automatic logic signed [12:0] sig_tab(input logic [5:0] k);
        logic signed [12:0] r;
        case (k)
            6'd0: r = 13'sd2048;  6'd1: r = 13'sd2303;  6'd2: r = 13'sd2550;
            6'd3: r = 13'sd2782;  6'd4: r = 13'sd2994;  6'd5: r = 13'sd3184;
            6'd6: r = 13'sd3349;  6'd7: r = 13'sd3490;  6'd8: r = 13'sd3608;
            6'd9: r = 13'sd3705;  6'd10: r = 13'sd3785; 6'd11: r = 13'sd3850;
            6'd12: r = 13'sd3902; 6'd13: r = 13'sd3943; 6'd14: r = 13'sd3976;
            6'd15: r = 13'sd4002; 6'd16: r = 13'sd4022; 6'd17: r = 13'sd4038;
            6'd18: r = 13'sd4051; 6'd19: r = 13'sd4061; 6'd20: r = 13'sd4069;
            6'd21: r = 13'sd4075; 6'd22: r = 13'sd4079; 6'd23: r = 13'sd4083;
            6'd24: r = 13'sd4086; 6'd25: r = 13'sd4088; 6'd26: r = 13'sd4090;
            6'd27: r = 13'sd4091; 6'd28: r = 13'sd4092; 6'd29: r = 13'sd4093;
            6'd30: r = 13'sd4094; 6'd31: r = 13'sd4094;
            default: r = 13'sd4095;
        endcase
        return r;
    endfunction

    // sigmoid of a 17-bit signed Q.12 value, result Q.12 in [1,4095]
    function automatic logic signed [13:0] sigm(input logic signed [16:0] x);
        logic [16:0] m;
        logic [6:0]  idx;
        logic [9:0]  fr;
        logic signed [12:0] t0, t1;
        logic signed [23:0] dt, fx;
        logic signed [23:0] d;
        logic signed [13:0] y;
        m   = x[16] ? 17'(-x) : x;
        idx = m[16:10];
        fr  = m[9:0];
        t0  = sig_tab(idx[5:0]);
        t1  = sig_tab(6'(idx[5:0] + 6'd1));
        dt  = 24'(t1) - 24'(t0);
        fx  = 24'($signed({1'b0, fr}));
        d   = dt * fx;
        if (idx >= 7'd32) y = 14'sd4095;
        else y = 14'(t0 + 13'(d >>> 10));
        return x[16] ? 14'(14'sd4096 - y) : y;
    endfunction

    // tanh(x) = 2*sigmoid(2x) - 1, 2x kept at 17 bits
    function automatic logic signed [15:0] tanh_q(input logic signed [15:0] x);
        logic signed [13:0] s;
        logic signed [15:0] s2;
        s  = sigm({x, 1'b0});
        s2 = 16'(s);
        return (s2 <<< 1) - 16'sd4096;
    endfunction

    function automatic logic signed [15:0] sat12(input logic signed [47:0] v);
        logic signed [35:0] q;
        q = 36'(v >>> 12);
        if (q > 36'sd32767) return 16'sd32767;
        if (q < -36'sd32768) return -16'sd32768;
        return q[15:0];
    endfunction
endpackage

// File: hdl/lcdh_if.sv
// ----------------------------------------------------------------------------
// lcdh_if
// Valid/ready channels: item in, prediction out, config write.
// ----------------------------------------------------------------------------
interface lcdh_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [11:0] slot;
    logic signed [15:0] value;
    modport source (output valid, kind, slot, value, input ready);
    modport sink   (input valid, kind, slot, value, output ready);
endinterface

interface lcdh_out_if;
    logic        valid;
    logic        ready;
    logic signed [15:0] prediction;
    modport source (output valid, prediction, input ready);
    modport sink   (input valid, prediction, output ready);
endinterface

interface lcdh_cfg_if;
    logic        valid;
    logic        ready;
    logic signed [15:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// File: hdl/lstm_cell_with_dense_head.sv
// ----------------------------------------------------------------------------
// lstm_cell_with_dense_head
// One-input LSTM layer, Q4.12, with a linear output head.
// ----------------------------------------------------------------------------
// Load and clear items can follow back to back. A step item runs, per
// hidden unit and gate, an input-weight step, a recurrent-weight step per
// recurrent column, a wait for the last product to land and an activation
// step, then the cell and hidden update steps per unit; a settle step, a
// dense step per unit and a finish step follow. Each recurrent weight is
// read through the registered-read weight memory before it reaches the
// accumulator. The prediction sits in an output register; the next item
// is taken only once it is transferred.
module lstm_cell_with_dense_head #(
    parameter int HIDDEN_UNITS = 8
) (
    input logic i_clk,
    input logic i_rst_n,
    lcdh_in_if.sink    in_ch,
    lcdh_out_if.source out_ch,
    lcdh_cfg_if.sink   cfg_ch
);
    import lcdh_pkg::*;
    logic signed [15:0] r_bias;
    logic r_ov;
    logic signed [15:0] r_pr;
    logic busy, done, acc_in;
    t_cmd cmd;
    logic signed [15:0] pred;

    assign cfg_ch.ready = 1'b1;
    assign in_ch.ready  = !busy && !r_ov && !done;
    assign acc_in = in_ch.valid && in_ch.ready;
    assign out_ch.valid = r_ov;
    assign out_ch.prediction = r_pr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias <= '0; r_ov <= 1'b0;
        end else begin
            if (cfg_ch.valid) r_bias <= cfg_ch.data;
            if (done) begin r_ov <= 1'b1; r_pr <= pred; end
            else if (out_ch.ready) r_ov <= 1'b0;
        end
    end

    lcdh_ctrl #(.H(HIDDEN_UNITS)) u_ctrl (
        .i_clk, .i_rst_n,
        .i_start(acc_in && in_ch.kind == K_STEP),
        .i_clear(acc_in && in_ch.kind == K_CLEAR),
        .o_busy(busy), .o_cmd(cmd)
    );

    lcdh_dp #(.H(HIDDEN_UNITS)) u_dp (
        .i_clk, .i_rst_n, .i_ld(acc_in), .i_kind(in_ch.kind), .i_slot(in_ch.slot),
        .i_value(in_ch.value), .i_bias(r_bias), .i_cmd(cmd),
        .o_done(done), .o_pred(pred)
    );
endmodule

// File: hdl/lcdh_ctrl.sv
// ----------------------------------------------------------------------------
// lcdh_ctrl
// Step sequencer: walks gates, recurrent columns, cell update, dense pass.
// ----------------------------------------------------------------------------
module lcdh_ctrl #(
    parameter int H = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_clear,
    output logic          o_busy,
    output lcdh_pkg::t_cmd o_cmd
);
    import lcdh_pkg::*;
    localparam int UW = $clog2(H + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_GX, S_GR, S_GW, S_GA, S_CELL, S_HT, S_HM, S_HW, S_DNS, S_FIN
    } t_st;
    t_st r_st;
    logic [1:0] r_g;
    logic [UW-1:0] r_u, r_j;
    t_cmd r_cmd;

    assign o_cmd  = r_cmd;
    // the done command goes out while already idle; hold off input for it
    assign o_busy = (r_st != S_IDLE) || (r_cmd.op == OP_DONE);

    always_ff @(posedge i_clk) begin
        r_cmd <= '0;
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_g <= '0; r_u <= '0; r_j <= '0;
        end else begin
            case (r_st)
                S_IDLE: begin
                    r_cmd.clear <= i_clear;
                    if (i_start) begin
                        r_st <= S_GX; r_u <= '0; r_g <= '0;
                    end
                end
                S_GX: begin
                    r_cmd.op <= OP_GATE_X; r_cmd.gate <= r_g; r_cmd.unit <= 5'(r_u);
                    r_j <= '0; r_st <= S_GR;
                end
                S_GR: begin
                    r_cmd.op <= OP_GATE_REC; r_cmd.gate <= r_g;
                    r_cmd.unit <= 5'(r_u); r_cmd.col <= 5'(r_j);
                    if (r_j == UW'(H - 1)) r_st <= S_GW;
                    r_j <= r_j + 1'b1;
                end
                // last recurrent product lands in the accumulator
                S_GW: r_st <= S_GA;
                S_GA: begin
                    r_cmd.op <= OP_GATE_ACT; r_cmd.gate <= r_g; r_cmd.unit <= 5'(r_u);
                    r_g <= r_g + 1'b1;
                    r_st <= (r_g == 2'd3) ? S_CELL : S_GX;
                end
                S_CELL: begin
                    r_cmd.op <= OP_CELL; r_cmd.unit <= 5'(r_u); r_st <= S_HT;
                end
                S_HT: begin
                    r_cmd.op <= OP_HTANH; r_cmd.unit <= 5'(r_u);
                    r_cmd.first <= 1'b1; r_st <= S_HM;
                end
                S_HM: begin
                    r_cmd.op <= OP_HTANH; r_cmd.unit <= 5'(r_u);
                    if (r_u == UW'(H - 1)) begin
                        r_u <= '0; r_st <= S_HW;
                    end else begin
                        r_u <= r_u + 1'b1; r_st <= S_GX;
                    end
                end
                // last hidden value is captured
                S_HW: r_st <= S_DNS;
                S_DNS: begin
                    r_cmd.op <= OP_DENSE; r_cmd.unit <= 5'(r_u);
                    r_cmd.first <= (r_u == '0);
                    if (r_u == UW'(H - 1)) r_st <= S_FIN;
                    r_u <= r_u + 1'b1;
                end
                S_FIN: begin
                    r_cmd.op <= OP_DONE; r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

// File: hdl/lcdh_dp.sv
// ----------------------------------------------------------------------------
// lcdh_dp
// Weight stores, state vectors, a single accumulator and the activation logic.
// ----------------------------------------------------------------------------
module lcdh_dp #(
    parameter int H = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_ld,
    input  logic [2:0]    i_kind,
    input  logic [11:0]   i_slot,
    input  logic signed [15:0] i_value,
    input  logic signed [15:0] i_bias,
    input  lcdh_pkg::t_cmd i_cmd,
    output logic          o_done,
    output logic signed [15:0] o_pred
);
    import lcdh_pkg::*;
    localparam int UW = (H > 1) ? $clog2(H) : 1;
    localparam int RW = $clog2(4 * H);
    localparam int MW = $clog2(4 * H * H);
    localparam int NR = 4 * H;
    localparam int NM = 4 * H * H;

    logic signed [15:0] r_win [NR];
    logic signed [15:0] r_bia [NR];
    logic signed [15:0] r_rec [NM];
    logic signed [15:0] r_wd  [H];
    logic signed [15:0] r_h   [H];
    logic signed [15:0] r_nh  [H];     // new hidden vector, built unit by unit
    logic signed [15:0] r_c   [H];
    logic signed [15:0] r_gt  [4];
    logic signed [15:0] r_x;
    logic signed [47:0] r_acc;
    logic signed [15:0] r_rw;      // registered recurrent weight read
    logic               r_rv;
    logic [UW-1:0]      r_rj;
    logic               r_ht;      // acc holds o*tanh(c) of unit r_hu
    logic [UW-1:0]      r_hu;
    logic               r_done;
    logic signed [15:0] r_pred;

    logic [RW-1:0] row;
    logic [UW-1:0] uu, jj;
    logic signed [15:0] pre, act;
    logic signed [31:0] p1, p2;

    assign uu  = i_cmd.unit[UW-1:0];
    assign jj  = i_cmd.col[UW-1:0];
    assign row = RW'(i_cmd.gate) * RW'(H) + RW'(uu);
    assign pre = sat12(r_acc);
    assign act = (i_cmd.gate == 2'd2) ? tanh_q(pre) : 16'(sigm({pre[15], pre}));
    assign o_done = r_done;
    assign o_pred = r_pred;

    // recurrent memory: one write port and one read port, read registered
    always_ff @(posedge i_clk) begin
        if (i_ld && i_kind == K_LOAD_REC && {20'd0, i_slot} < 32'(NM))
            r_rec[i_slot[MW-1:0]] <= i_value;
        r_rw <= r_rec[MW'(row) * MW'(H) + MW'(jj)];
        r_rj <= jj;
    end

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            case (i_kind)
                K_LOAD_IN:  if ({20'd0, i_slot} < 32'(NR)) r_win[i_slot[RW-1:0]] <= i_value;
                K_LOAD_BIA: if ({20'd0, i_slot} < 32'(NR)) r_bia[i_slot[RW-1:0]] <= i_value;
                K_LOAD_DNS: if ({20'd0, i_slot} < 32'(H)) r_wd[i_slot[UW-1:0]] <= i_value;
                K_STEP:     r_x <= i_value;
                default: ;
            endcase
        end
    end

    // cell path: two products summed and registered into the accumulator
    assign p1 = r_gt[1] * r_c[uu] + 32'sd0;
    assign p2 = r_gt[0] * r_gt[2];

    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        if (!i_rst_n) begin
            for (int k = 0; k < H; k++) begin r_h[k] <= '0; r_c[k] <= '0; end
            r_rv <= 1'b0;
            r_ht <= 1'b0;
        end else begin
            r_rv <= (i_cmd.op == OP_GATE_REC);
            r_ht <= (i_cmd.op == OP_HTANH) && !i_cmd.first;
            r_hu <= uu;
            if (r_rv) r_acc <= r_acc + 48'(r_rw) * 48'(r_h[r_rj]);
            case (i_cmd.op)
                OP_GATE_X:
                    r_acc <= 48'(r_win[row]) * 48'(r_x) + (48'(r_bia[row]) <<< 12);
                OP_GATE_ACT: r_gt[i_cmd.gate] <= act;
                OP_CELL: r_acc <= 48'(p1) + 48'(p2);
                OP_HTANH: begin
                    // forget gate is spent; its slot keeps tanh(c)
                    if (i_cmd.first) begin
                        r_c[uu] <= pre;
                        r_gt[1] <= tanh_q(pre);
                    end else begin
                        r_acc <= 48'(r_gt[3]) * 48'(r_gt[1]);
                    end
                end
                OP_DENSE: begin
                    if (i_cmd.first) begin
                        r_acc <= (48'(i_bias) <<< 12) + 48'(r_nh[uu]) * 48'(r_wd[uu]);
                        for (int k = 0; k < H; k++) r_h[k] <= r_nh[k];
                    end else begin
                        r_acc <= r_acc + 48'(r_nh[uu]) * 48'(r_wd[uu]);
                    end
                end
                OP_DONE: begin r_pred <= pre; r_done <= 1'b1; end
                default: ;
            endcase
            // hidden vector is swapped in only after all units have their gates
            if (r_ht) r_nh[r_hu] <= pre;
            if (i_cmd.clear)
                for (int k = 0; k < H; k++) begin r_h[k] <= '0; r_c[k] <= '0; end
        end
    end
endmodule

// File: hdl/lcdh_chk.sv
// ----------------------------------------------------------------------------
// lcdh_chk
// Port-level checks on the top level.
// ----------------------------------------------------------------------------
`include "lstm_cell_with_dense_head_defines.svh"
module lcdh_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready
);
    `LCDH_ASSERT_IMP(a_no_in_while_out, i_clk, i_rst_n, out_valid, !in_ready)
    `LCDH_ASSERT_NXT(a_out_holds, i_clk, i_rst_n, out_valid && !out_ready, out_valid)
    `LCDH_ASSERT_NXT(a_no_out_after_take, i_clk, i_rst_n, out_valid && out_ready, !out_valid)
endmodule

bind lstm_cell_with_dense_head lcdh_chk u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready)
);
